@@ rtl/postfix_expression_evaluator_defines.svh @@
// assertion macros for the postfix expression evaluator
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PFX_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("same-cycle check failed");
`define PFX_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define PFX_ASSERT_IMP(label, clk, rst_n, pre, post)
`define PFX_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

@@ rtl/pfx_pkg.sv @@
// shared types, codes and helpers of the postfix evaluator
`default_nettype none
package pfx_pkg;

    localparam int PFX_STACK_DEPTH = 16;

    localparam logic [7:0] SYM_END   = 8'h00;
    localparam logic [7:0] SYM_ZERO  = 8'h30;
    localparam logic [7:0] SYM_NINE  = 8'h39;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_STAR  = 8'h2A;
    localparam logic [7:0] SYM_SLASH = 8'h2F;
    localparam logic [7:0] SYM_POW   = 8'h24;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd1;
    localparam logic [1:0] STATUS_MATH    = 2'd2;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_EMPTY = -32'sd1;

    typedef enum logic [1:0] {SC_DIGIT, SC_OPER, SC_END, SC_ILLEGAL} t_sym_class;
    typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW} t_op;

    typedef enum logic [3:0] {
        DP_NOP, DP_DIGIT, DP_LOAD_B, DP_LOAD_A, DP_ADDSUB, DP_MUL, DP_MUL_FIX,
        DP_DIV_INIT, DP_DIV_STEP, DP_DIV_FIX, DP_POW_INIT, DP_POW_STEP,
        DP_POW_FIX, DP_PUSH, DP_TERM, DP_ILL
    } t_dpop;

    typedef enum logic [3:0] {
        S_IDLE, S_OP_B, S_OP_A, S_EXEC, S_MUL_FIX, S_DIV_STEP, S_DIV_FIX,
        S_POW_STEP, S_POW_FIX, S_PUSH, S_TERM, S_ILL
    } t_state;

    typedef struct packed {
        t_dpop dpop;
        t_op   op;
        logic  rd_second;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic div_zero;
        logic pow_trivial;
        logic pow_done;
        logic div_last;
    } t_dp_status;

    function automatic t_sym_class f_class(input logic [7:0] sym);
        t_sym_class c;
        if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
            c = SC_DIGIT;
        end else if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_STAR ||
                     sym == SYM_SLASH || sym == SYM_POW) begin
            c = SC_OPER;
        end else if (sym == SYM_END) begin
            c = SC_END;
        end else begin
            c = SC_ILLEGAL;
        end
        return c;
    endfunction

    function automatic t_op f_op(input logic [7:0] sym);
        t_op o;
        if (sym == SYM_PLUS) begin
            o = OP_ADD;
        end else if (sym == SYM_MINUS) begin
            o = OP_SUB;
        end else if (sym == SYM_STAR) begin
            o = OP_MUL;
        end else if (sym == SYM_SLASH) begin
            o = OP_DIV;
        end else begin
            o = OP_POW;
        end
        return o;
    endfunction

    function automatic logic [31:0] f_mag(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

endpackage
`default_nettype wire

@@ rtl/pfx_ram.sv @@
// generic single-write single-read ram with registered read
`default_nettype none
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = pfx_pkg::PFX_STACK_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/pfx_dp.sv @@
// datapath: operand stack, arithmetic units and result register
`default_nettype none
module pfx_dp #(
    parameter int STACK_DEPTH = pfx_pkg::PFX_STACK_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pfx_pkg::t_cmd      i_cmd,
    output pfx_pkg::t_dp_status     o_dp_status,
    input  wire logic [7:0]         i_symbol,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output logic signed [31:0]      o_value,
    output logic [1:0]              o_status
);
    import pfx_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0]      r_cnt;
    logic               r_err;
    logic               r_ov;
    logic signed [31:0] r_a, r_b, r_res, r_val;
    logic [31:0]        r_ma, r_mb, r_q, r_rem;
    logic [63:0]        r_prod;
    logic [32:0]        r_m;
    logic [5:0]         r_iter;
    logic [1:0]         r_st;

    logic [CW-1:0]      cnt_m1, cnt_m2;
    logic               full, ge1, ge2;
    logic               we;
    logic [AW-1:0]      raddr;
    logic [31:0]        wdata, rdata;
    logic signed [31:0] digit, pop_b, pop_a;
    logic [31:0]        mul_x, mul_y;
    logic [63:0]        mul_p;
    logic signed [32:0] s33;
    logic signed [31:0] addsub_sat, mul_fix, div_fix, pow_fix, pow_triv_val;
    logic [32:0]        trial, diff;
    logic               qbit, pow_zero_neg;

    assign cnt_m1 = r_cnt - CW'(1);
    assign cnt_m2 = r_cnt - CW'(2);
    assign full   = (r_cnt == CW'(STACK_DEPTH));
    assign ge1    = (r_cnt != '0);
    assign ge2    = (r_cnt >= CW'(2));
    assign raddr  = i_cmd.rd_second ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
    assign digit  = signed'({24'd0, 8'(i_symbol - SYM_ZERO)});
    assign we     = !full && (i_cmd.dpop == DP_DIGIT || i_cmd.dpop == DP_PUSH);
    assign wdata  = (i_cmd.dpop == DP_DIGIT) ? digit : r_res;
    assign pop_b  = ge1 ? signed'(rdata) : VAL_EMPTY;
    assign pop_a  = ge2 ? signed'(rdata) : VAL_EMPTY;

    pfx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // one shared unsigned multiplier for products and power steps
    assign mul_x = (i_cmd.dpop == DP_POW_STEP) ? r_m[31:0] : r_ma;
    assign mul_y = (i_cmd.dpop == DP_POW_STEP) ? r_ma : r_mb;
    assign mul_p = mul_x * mul_y;

    always_comb begin
        if (i_cmd.op == OP_SUB) begin
            s33 = {r_a[31], r_a} - {r_b[31], r_b};
        end else begin
            s33 = {r_a[31], r_a} + {r_b[31], r_b};
        end
        if (s33[32] != s33[31]) begin
            addsub_sat = s33[32] ? VAL_MIN : VAL_MAX;
        end else begin
            addsub_sat = s33[31:0];
        end
    end

    always_comb begin
        if (r_a[31] ^ r_b[31]) begin
            mul_fix = (r_prod > 64'h8000_0000) ? VAL_MIN : signed'(32'(-r_prod[31:0]));
        end else begin
            mul_fix = (r_prod > 64'h7FFF_FFFF) ? VAL_MAX : signed'(r_prod[31:0]);
        end
    end

    assign trial = {r_rem, r_q[31]};
    assign diff  = trial - {1'b0, r_mb};
    assign qbit  = (trial >= {1'b0, r_mb});

    always_comb begin
        if (r_a[31] ^ r_b[31]) begin
            div_fix = signed'(32'(-r_q));
        end else begin
            div_fix = (r_q == 32'h8000_0000) ? VAL_MAX : signed'(r_q);
        end
    end

    assign pow_zero_neg = (r_a == 0) && r_b[31];

    always_comb begin
        if (r_b == 0) begin
            pow_triv_val = 32'sd1;
        end else if (r_a == 0) begin
            pow_triv_val = 32'sd0;
        end else if (r_a == 32'sd1) begin
            pow_triv_val = 32'sd1;
        end else if (r_a == -32'sd1) begin
            pow_triv_val = r_b[0] ? -32'sd1 : 32'sd1;
        end else begin
            pow_triv_val = 32'sd0;
        end
    end

    always_comb begin
        if (r_a[31] && r_b[0]) begin
            pow_fix = (r_m > 33'h0_8000_0000) ? VAL_MIN : signed'(32'(-r_m[31:0]));
        end else begin
            pow_fix = (r_m > 33'h0_7FFF_FFFF) ? VAL_MAX : signed'(r_m[31:0]);
        end
    end

    assign o_dp_status.out_free    = !r_ov || !i_out_stall;
    assign o_dp_status.div_zero    = (r_b == 0);
    assign o_dp_status.pow_trivial = (r_b == 0) || (r_a == 0) || (r_a == 32'sd1) ||
                                     (r_a == -32'sd1) || r_b[31];
    assign o_dp_status.pow_done    = (32'(r_iter) >= unsigned'(r_b)) ||
                                     (r_m > 33'h0_8000_0000);
    assign o_dp_status.div_last    = (r_iter == 6'd31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_err <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            // a new result loads the slot, otherwise it empties once taken
            r_ov <= (i_cmd.dpop == DP_TERM) || (i_cmd.dpop == DP_ILL) ||
                    (r_ov && i_out_stall);
            unique case (i_cmd.dpop)
                DP_DIGIT, DP_PUSH: begin
                    if (!full) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                DP_LOAD_A: r_cnt <= ge2 ? cnt_m2 : '0;
                DP_DIV_INIT: begin
                    if (r_b == 0) begin
                        r_err <= 1'b1;
                    end
                end
                DP_POW_INIT: begin
                    if (pow_zero_neg) begin
                        r_err <= 1'b1;
                    end
                end
                DP_TERM, DP_ILL: begin
                    r_cnt <= '0;
                    r_err <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.dpop)
            DP_LOAD_B: begin
                r_b  <= pop_b;
                r_mb <= f_mag(pop_b);
            end
            DP_LOAD_A: begin
                r_a  <= pop_a;
                r_ma <= f_mag(pop_a);
            end
            DP_ADDSUB:  r_res  <= addsub_sat;
            DP_MUL:     r_prod <= mul_p;
            DP_MUL_FIX: r_res  <= mul_fix;
            DP_DIV_INIT: begin
                r_res  <= '0;
                r_q    <= r_ma;
                r_rem  <= '0;
                r_iter <= '0;
            end
            DP_DIV_STEP: begin
                r_q    <= {r_q[30:0], qbit};
                r_rem  <= qbit ? diff[31:0] : trial[31:0];
                r_iter <= r_iter + 6'd1;
            end
            DP_DIV_FIX: r_res <= div_fix;
            DP_POW_INIT: begin
                r_res  <= pow_triv_val;
                r_m    <= 33'd1;
                r_iter <= '0;
            end
            DP_POW_STEP: begin
                if (!o_dp_status.pow_done) begin
                    r_m    <= (mul_p > 64'h8000_0000) ? 33'h0_8000_0001 : mul_p[32:0];
                    r_iter <= r_iter + 6'd1;
                end
            end
            DP_POW_FIX: r_res <= pow_fix;
            DP_TERM: begin
                r_val <= pop_b;
                r_st  <= r_err ? STATUS_MATH : STATUS_OK;
            end
            DP_ILL: begin
                r_val <= '0;
                r_st  <= STATUS_ILLEGAL;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_value     = r_val;
    assign o_status    = r_st;
endmodule
`default_nettype wire

@@ rtl/pfx_ctrl.sv @@
// controller state machine sequencing pops, arithmetic and results
`default_nettype none
module pfx_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [7:0]          i_symbol,
    output logic                     o_in_stall,
    input  wire pfx_pkg::t_dp_status i_dp_status,
    output pfx_pkg::t_cmd            o_cmd
);
    import pfx_pkg::*;

    t_state     r_state, n_state;
    t_op        r_op, n_op;
    t_sym_class cls;

    assign cls = f_class(i_symbol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_ADD;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (cls)
                        SC_DIGIT: n_state = S_IDLE;
                        SC_OPER: begin
                            n_state = S_OP_B;
                            n_op    = f_op(i_symbol);
                        end
                        SC_END:     n_state = S_TERM;
                        SC_ILLEGAL: n_state = S_ILL;
                    endcase
                end
            end
            S_OP_B: n_state = S_OP_A;
            S_OP_A: n_state = S_EXEC;
            S_EXEC: begin
                unique case (r_op)
                    OP_ADD, OP_SUB: n_state = S_PUSH;
                    OP_MUL:         n_state = S_MUL_FIX;
                    OP_DIV: n_state = i_dp_status.div_zero ? S_PUSH : S_DIV_STEP;
                    OP_POW: n_state = i_dp_status.pow_trivial ? S_PUSH : S_POW_STEP;
                    default:        n_state = S_PUSH;
                endcase
            end
            S_MUL_FIX: n_state = S_PUSH;
            S_DIV_STEP: begin
                if (i_dp_status.div_last) begin
                    n_state = S_DIV_FIX;
                end
            end
            S_DIV_FIX: n_state = S_PUSH;
            S_POW_STEP: begin
                if (i_dp_status.pow_done) begin
                    n_state = S_POW_FIX;
                end
            end
            S_POW_FIX: n_state = S_PUSH;
            S_PUSH:    n_state = S_IDLE;
            S_TERM, S_ILL: begin
                if (i_dp_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        o_cmd.dpop      = DP_NOP;
        o_cmd.op        = r_op;
        o_cmd.rd_second = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && cls == SC_DIGIT) begin
                    o_cmd.dpop = DP_DIGIT;
                end
            end
            S_OP_B: begin
                o_cmd.dpop      = DP_LOAD_B;
                o_cmd.rd_second = 1'b1;
            end
            S_OP_A: o_cmd.dpop = DP_LOAD_A;
            S_EXEC: begin
                unique case (r_op)
                    OP_ADD, OP_SUB: o_cmd.dpop = DP_ADDSUB;
                    OP_MUL:         o_cmd.dpop = DP_MUL;
                    OP_DIV:         o_cmd.dpop = DP_DIV_INIT;
                    OP_POW:         o_cmd.dpop = DP_POW_INIT;
                    default:        o_cmd.dpop = DP_NOP;
                endcase
            end
            S_MUL_FIX:  o_cmd.dpop = DP_MUL_FIX;
            S_DIV_STEP: o_cmd.dpop = DP_DIV_STEP;
            S_DIV_FIX:  o_cmd.dpop = DP_DIV_FIX;
            S_POW_STEP: o_cmd.dpop = DP_POW_STEP;
            S_POW_FIX:  o_cmd.dpop = DP_POW_FIX;
            S_PUSH:     o_cmd.dpop = DP_PUSH;
            S_TERM: begin
                if (i_dp_status.out_free) begin
                    o_cmd.dpop = DP_TERM;
                end
            end
            S_ILL: begin
                if (i_dp_status.out_free) begin
                    o_cmd.dpop = DP_ILL;
                end
            end
            default: o_cmd.dpop = DP_NOP;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/postfix_expression_evaluator.sv @@
// top level of the postfix expression evaluator
// usage:
//   input channel: one ascii symbol per beat on i_symbol, taken when i_in_valid
//   is high and o_in_stall is low. digits push, + - * / $ pop two operands and
//   push the saturated result, the zero symbol ends the expression, anything
//   else is rejected.
//   output channel: one beat per end symbol or rejected symbol, o_value and
//   o_status held in an output register until taken (o_out_valid high, i_out_stall
//   low). a held result does not block digits or operators.
// work per symbol:
//   multiply: two reads through the registered
//   stack ram, then the shared 32x32 multiplier and a saturation stage.
//   divide: the radix-2 divider loop doing one quotient bit a cycle.
//   power: one multiply per cycle of the repeated multiply loop
//   until the exponent is used up or the magnitude passes 2^31.
//   end or rejected symbol: waits while the previous result is
//   still stalled in the output register.
// reset: synchronous active-low, empties the stack, clears the error flag and
//   the output valid flag; stack contents and the held value are not cleared.
`default_nettype none
module postfix_expression_evaluator
    #(
    parameter int STACK_DEPTH = pfx_pkg::PFX_STACK_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_symbol,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status
);
    import pfx_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;

    // sequencer
    pfx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_symbol    (i_symbol),
        .o_in_stall  (o_in_stall),
        .i_dp_status (dp_status),
        .o_cmd       (cmd)
    );

    // stack, arithmetic and output register
    pfx_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_dp_status (dp_status),
        .i_symbol    (i_symbol),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .o_status    (o_status)
    );

`include "postfix_expression_evaluator_defines.svh"

    // a result is only written when the output slot is free
    `PFX_ASSERT_IMP(a_load_free, i_clk, i_rst_n, (cmd.dpop == DP_TERM || cmd.dpop == DP_ILL), dp_status.out_free)
    // a loaded result shows up as a valid beat next cycle
    `PFX_ASSERT_NXT(a_load_shows, i_clk, i_rst_n, (cmd.dpop == DP_TERM || cmd.dpop == DP_ILL), o_out_valid)
    // while input is open the datapath does at most a digit push
    `PFX_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, !o_in_stall, (cmd.dpop == DP_NOP || cmd.dpop == DP_DIGIT))

endmodule
`default_nettype wire
